@@ sv/dsa_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsa_pkg
// Shared types and codes for the descriptor slot allocator.
// -----------------------------------------------------------------------------
package dsa_pkg;

   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int SIZE_W = 16;
   localparam int ADDR_W = 64;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_NOT_HELD = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_SLOT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_SLOT_SIZE    = 2'd1;
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd2;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] free_slot;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  slot_index;
      logic [ADDR_W-1:0] slot_address;
      logic [1:0]        status;
      logic [CNT_W-1:0]  active_slots;
   } rsp_type;

   // Command to the free stack
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [IDX_W-1:0] wdata;
   } stack_cmd_type;

   // Free stack status
   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

@@ sv/dsa_free_stack.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dsa_free_stack
// LIFO of freed slot indices in one synchronous RAM with a depth pointer.
// -----------------------------------------------------------------------------
module dsa_free_stack #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dsa_pkg::stack_cmd_type  cmd,
   output dsa_pkg::stack_stat_type stat,
   output logic [dsa_pkg::IDX_W-1:0] rdata
);
   import dsa_pkg::*;

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);

   logic [IDX_W-1:0] mem [MAX_SLOTS];
   logic [CW-1:0]    depth_ff;
   logic [CW-1:0]    depth_in;
   logic [CW-1:0]    top_addr;
   logic [IDX_W-1:0] rdata_ff;

   assign top_addr = depth_ff - CW'(1);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + CW'(1);
      end else if (cmd.pop) begin
         depth_in = top_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // RAM: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[depth_ff[AW-1:0]] <= cmd.wdata;
      end
      if (cmd.pop) begin
         rdata_ff <= mem[top_addr[AW-1:0]];
      end
   end

   assign stat.empty = (depth_ff == '0);
   assign stat.full  = (depth_ff == CW'(MAX_SLOTS));
   assign rdata      = rdata_ff;

`ifndef SYNTHESIS
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in the same cycle");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty)
      else $error("pop from empty free stack");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push to full free stack");
   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> depth_ff == $past(depth_ff) + CW'(1))
      else $error("depth did not advance on push");
`endif

endmodule

@@ sv/descriptor_slot_allocator.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// descriptor_slot_allocator
// Bump allocator with a LIFO free list for a fixed heap of descriptor slots.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the transaction is taken
//   at the edge where start is high and busy is low. action ALLOC hands out
//   the next fresh slot (rising order up to slot_count, capped at MAX_SLOTS), then the most
//   recently freed one; action FREE returns free_slot to the free stack.
//   Response channel: rsp_valid strobes for exactly one cycle with the index,
//   base_address + index * slot_size (mod 2^64), status and held count.
//   The receiver cannot stall; every response must be taken as it appears.
//   The response is formed through the idx_ff, product_ff and rsp_ff
//   registers in that order, and rsp_valid rises with rsp_ff. No new
//   transaction is taken while busy is high; busy is high for the one
//   cycle in which the free-stack RAM read returns and the multiply runs.
//   CSR channel: csr_valid/csr_ready write of slot_count, slot_size or
//   base_address by csr_index; only while no transaction is in flight.
//   Reset (synchronous): counters cleared, CSRs to slot_count 1024,
//   slot_size 32, base 0; free-stack RAM contents are not cleared.
//   Exhaustion and a free with nothing held return a status and change
//   no state.
// -----------------------------------------------------------------------------
module descriptor_slot_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dsa_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output dsa_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [dsa_pkg::ADDR_W-1:0] csr_wdata
);
   import dsa_pkg::*;

   localparam int CW = $clog2(MAX_SLOTS + 1);      // counter width
   localparam int UW = (CW > CNT_W) ? CW : CNT_W;  // compare width
   localparam int IW = (CW > IDX_W) ? CW : IDX_W;  // full index width
   localparam int PW = IW + SIZE_W;                // product width

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type state_ff;

   // CSRs
   logic [CNT_W-1:0]  slot_count_ff;
   logic [SIZE_W-1:0] slot_size_ff;
   logic [ADDR_W-1:0] base_ff;

   // Allocator counters
   logic [CW-1:0] next_fresh_ff, next_fresh_in;
   logic [CW-1:0] held_ff, held_in;

   // Per-transaction context
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    status_ff, status_in;
   logic          pop_ff;
   logic [PW-1:0] product_ff;
   logic          add_pend_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic           accept;
   logic [UW-1:0]  usable;
   logic           fresh_ok;
   logic [IW-1:0]  calc_idx;
   stack_cmd_type  stk_cmd;
   stack_stat_type stk_stat;
   logic [IDX_W-1:0] stk_rdata;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff == ST_CALC);
   assign csr_ready = (state_ff == ST_IDLE) && !add_pend_ff;

   // Slot counts above MAX_SLOTS clamp to MAX_SLOTS
   assign usable   = (UW'(slot_count_ff) > UW'(MAX_SLOTS)) ? UW'(MAX_SLOTS)
                                                            : UW'(slot_count_ff);
   assign fresh_ok = UW'(next_fresh_ff) < usable;

   // Decide the transaction at the accepting edge
   always_comb begin
      next_fresh_in = next_fresh_ff;
      held_in       = held_ff;
      idx_in        = '0;
      status_in     = STATUS_OK;
      stk_cmd       = '0;
      stk_cmd.wdata = req_data.free_slot;
      if (accept) begin
         if (req_data.action == ACT_ALLOC) begin
            if (fresh_ok) begin
               idx_in        = IW'(next_fresh_ff);
               next_fresh_in = next_fresh_ff + CW'(1);
               held_in       = held_ff + CW'(1);
            end else if (!stk_stat.empty) begin
               stk_cmd.pop = 1'b1;
               held_in     = held_ff + CW'(1);
            end else begin
               status_in = STATUS_NO_SLOT;
            end
         end else begin
            idx_in = IW'(req_data.free_slot);
            if (held_ff == '0 || stk_stat.full) begin
               status_in = STATUS_NOT_HELD;
            end else begin
               stk_cmd.push = 1'b1;
               held_in      = held_ff - CW'(1);
            end
         end
      end
   end

   // Popped index arrives from the RAM in the cycle after the accept
   assign calc_idx = pop_ff ? IW'(stk_rdata) : idx_ff;

   dsa_free_stack #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_free_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat),
      .rdata (stk_rdata)
   );

   // CSR writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= CNT_W'(1024);
         slot_size_ff  <= SIZE_W'(32);
         base_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOT_COUNT:   slot_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_SLOT_SIZE:    slot_size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_BASE_ADDRESS: base_ff       <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_fresh_ff <= '0;
         held_ff       <= '0;
         pop_ff        <= 1'b0;
         add_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_fresh_ff <= next_fresh_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= add_pend_ff;
         add_pend_ff   <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pop_ff   <= stk_cmd.pop;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               add_pend_ff <= 1'b1;
               pop_ff      <= 1'b0;
               state_ff    <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath: index capture, multiply, then add into the response register
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= idx_in;
         status_ff <= status_in;
      end else if (state_ff == ST_CALC) begin
         idx_ff <= calc_idx;
      end
      if (state_ff == ST_CALC) begin
         product_ff <= PW'(calc_idx) * PW'(slot_size_ff);
      end
      if (add_pend_ff) begin
         rsp_ff.slot_index   <= idx_ff[IDX_W-1:0];
         rsp_ff.slot_address <= base_ff + ADDR_W'(product_ff);
         rsp_ff.status       <= status_ff;
         rsp_ff.active_slots <= CNT_W'(held_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_valid)
      else $error("response not produced three cycles after accept");
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(MAX_SLOTS))
      else $error("held count exceeds heap size");
`endif

endmodule
